// ----- hdl/plid_pkg.sv -----
// Package: shared types and codes for the positional list core.
`timescale 1ns / 1ps

package plid_pkg;

  localparam int unsigned LenW  = 7;
  localparam int unsigned PosW  = 6;
  localparam int unsigned WordW = 32;

  // Operation codes
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic {
    STATUS_OK     = 1'b0,
    STATUS_REJECT = 1'b1
  } status_e;

  // Request transaction
  typedef struct packed {
    logic [1:0]       func;
    logic [PosW-1:0]  position;
    logic [WordW-1:0] value;
  } req_t;

  // Result transaction
  typedef struct packed {
    logic             status;
    logic [WordW-1:0] read_data;
    logic [LenW-1:0]  current_length;
  } res_t;

  // Shift command broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [LenW-1:0]  pos;
    logic [WordW-1:0] word;
  } shift_cmd_t;

endpackage

// ----- hdl/positional_list_insert_delete_core.sv -----
// Top level: positional list core built as a row of shifting cells.
`timescale 1ns / 1ps
//
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+---------------------------
// request  | in        | start & !busy              | req_i  (func, position, value)
// result   | out       | res_valid_o, one-cycle     | res_o  (status, data, length)
// config   | in        | cfg_valid_i & cfg_ready_o  | cfg_data_i (capacity_limit)
//
// One request every cycle; its result is registered and shows in the cycle after
// acceptance. Every cell updates in parallel from its neighbors, so the whole row
// shifts at once. Reset clears the length and sets the capacity to 64; entries are
// undefined until written. The receiver cannot stall; busy stays low.

module positional_list_insert_delete_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  plid_pkg::req_t                 req_i,
  output logic                           res_valid_o,
  output plid_pkg::res_t                 res_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [plid_pkg::LenW-1:0]      cfg_data_i
);

  // Compare width: holds DEPTH and any 7-bit count
  localparam int unsigned DW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (DW > plid_pkg::LenW) ? DW : plid_pkg::LenW;
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [plid_pkg::LenW-1:0] CapReset = plid_pkg::LenW'(64);

  logic [plid_pkg::LenW-1:0] cap_q, len_q, len_d;
  logic                      res_valid_q;
  plid_pkg::res_t            res_q, res_d;
  plid_pkg::shift_cmd_t      cmd;
  logic                      accept;
  logic [CW-1:0]             cap_w, len_w, pos_w, eff_cap;
  logic [plid_pkg::WordW-1:0] cell_data [DEPTH];
  logic [plid_pkg::WordW-1:0] rd_word;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  assign cap_w   = CW'(cap_q);
  assign len_w   = CW'(len_q);
  assign pos_w   = CW'(req_i.position);
  assign eff_cap = (cap_w < DepthC) ? cap_w : DepthC;

  // Read port: select the addressed cell
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (pos_w == CW'(i)) rd_word = cell_data[i];
    end
  end

  // Decode request, check limits, build shift command and result
  always_comb begin
    cmd        = '0;
    cmd.word   = req_i.value;
    len_d      = len_q;
    res_d      = '0;
    res_d.status = plid_pkg::STATUS_OK;
    case (plid_pkg::func_e'(req_i.func))
      plid_pkg::FUNC_INSERT: begin
        if (len_w >= eff_cap || req_i.value == '0 || pos_w >= eff_cap) begin
          res_d.status = plid_pkg::STATUS_REJECT;
        end else begin
          cmd.ins = accept;
          cmd.pos = (pos_w > len_w) ? len_q : plid_pkg::LenW'(req_i.position);
          len_d   = len_q + 1'b1;
        end
      end
      plid_pkg::FUNC_READ: begin
        if (pos_w >= len_w || pos_w >= DepthC) begin
          res_d.status = plid_pkg::STATUS_REJECT;
        end else begin
          res_d.read_data = rd_word;
        end
      end
      plid_pkg::FUNC_DELETE: begin
        if (pos_w >= len_w || len_w > DepthC) begin
          res_d.status = plid_pkg::STATUS_REJECT;
        end else begin
          cmd.del = accept;
          cmd.pos = plid_pkg::LenW'(req_i.position);
          len_d   = len_q - 1'b1;
        end
      end
      plid_pkg::FUNC_CLEAR: begin
        len_d = '0;
      end
      default: begin
        len_d = len_q;
      end
    endcase
    res_d.current_length = len_d;
  end

  // Row of cells; the ends see zero from outside
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [plid_pkg::WordW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    plid_cell #(.IDX(g)) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[g])
    );
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapReset;
      len_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) cap_q <= cfg_data_i;
      if (accept) len_q <= len_d;
      res_valid_q <= accept;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (accept) res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- hdl/plid_cell.sv -----
// One list cell: holds one entry, loads, shifts up or shifts down.
`timescale 1ns / 1ps

module plid_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                          clk_i,
  input  plid_pkg::shift_cmd_t          cmd_i,
  input  logic [plid_pkg::WordW-1:0]    left_i,
  input  logic [plid_pkg::WordW-1:0]    right_i,
  output logic [plid_pkg::WordW-1:0]    data_o
);

  // Cells beyond the widest position are always past the target
  localparam bit Beyond = (IDX >= (1 << plid_pkg::LenW));
  localparam logic [plid_pkg::LenW-1:0] IdxNarrow = plid_pkg::LenW'(IDX);

  logic [plid_pkg::WordW-1:0] data_q, data_d;
  logic at_pos, past_pos;

  assign at_pos   = !Beyond && (IdxNarrow == cmd_i.pos);
  assign past_pos = Beyond || (IdxNarrow > cmd_i.pos);

  // Next entry value
  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (at_pos) data_d = cmd_i.word;
      else if (past_pos) data_d = left_i;
    end else if (cmd_i.del) begin
      if (at_pos || past_pos) data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- sim/tb_positional_list_insert_delete_core.sv -----
// Testbench for the positional list core: directed and random traffic checked against a predictor.
`timescale 1ns / 1ps

module tb_positional_list_insert_delete_core;

  localparam int unsigned LIST_DEPTH = 64;
  localparam int unsigned DRAIN_CYCLES = 4;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  plid_pkg::req_t                req_i;
  logic                          res_valid_o;
  plid_pkg::res_t                res_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [plid_pkg::LenW-1:0]     cfg_data_i;

  // Mirror of the list contents, length and capacity register
  logic [plid_pkg::WordW-1:0]    list_words [LIST_DEPTH];
  int                            list_len;
  int                            cap_limit;

  plid_pkg::res_t                expected_results [$];
  int                            error_count;

  positional_list_insert_delete_core #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Apply one request to the list mirror and return the result it should produce
  function automatic plid_pkg::res_t compute_list_result(plid_pkg::req_t item);
    plid_pkg::res_t r;
    int   eff_cap;
    int   p;
    int   i;
    eff_cap     = (cap_limit < LIST_DEPTH) ? cap_limit : LIST_DEPTH;
    r.status    = plid_pkg::STATUS_OK;
    r.read_data = '0;
    p           = item.position;
    case (plid_pkg::func_e'(item.func))
      plid_pkg::FUNC_INSERT: begin
        if (list_len >= eff_cap || item.value == '0 || p >= eff_cap) begin
          r.status = plid_pkg::STATUS_REJECT;
        end else begin
          if (p > list_len) p = list_len;  // append when past the end
          for (i = list_len; i > p; i--) list_words[i] = list_words[i-1];
          list_words[p] = item.value;
          list_len++;
        end
      end
      plid_pkg::FUNC_READ: begin
        if (p >= list_len) r.status = plid_pkg::STATUS_REJECT;
        else r.read_data = list_words[p];
      end
      plid_pkg::FUNC_DELETE: begin
        if (p >= list_len) begin
          r.status = plid_pkg::STATUS_REJECT;
        end else begin
          for (i = p; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_words[list_len-1] = '0;
          list_len--;
        end
      end
      default: begin
        list_len = 0;
      end
    endcase
    r.current_length = plid_pkg::LenW'(list_len);
    return r;
  endfunction

  function automatic plid_pkg::req_t make_req(plid_pkg::func_e f, int pos,
                                              logic [plid_pkg::WordW-1:0] v);
    plid_pkg::req_t item;
    item.func     = f;
    item.position = plid_pkg::PosW'(pos);
    item.value    = v;
    return item;
  endfunction

  // Send one request transaction; called and returns at a falling edge
  task automatic send_item(plid_pkg::req_t item, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    req_i = item;
    do @(posedge clk_i); while (busy);
    expected_results.push_back(compute_list_result(item));
    @(negedge clk_i);
  endtask

  // Wait until every expected result has come back, then let the pipe settle
  task automatic wait_results_drained();
    start = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Capacity register write, only with the core idle
  task automatic write_capacity(logic [plid_pkg::LenW-1:0] lim);
    wait_results_drained();
    cfg_valid_i = 1'b1;
    cfg_data_i  = lim;
    do @(posedge clk_i); while (!cfg_ready_o);
    cap_limit = lim;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Result checker
  always @(posedge clk_i) begin : check_result
    plid_pkg::res_t want;
    if (rst_ni && res_valid_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: status %0b data %h length %0d", $time,
                 res_o.status, res_o.read_data, res_o.current_length);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (res_o.status !== want.status) begin
          $display("%0t: status mismatch: expected %0b actual %0b", $time,
                   want.status, res_o.status);
          error_count++;
        end
        if (res_o.read_data !== want.read_data) begin
          $display("%0t: read_data mismatch: expected %h actual %h", $time,
                   want.read_data, res_o.read_data);
          error_count++;
        end
        if (res_o.current_length !== want.current_length) begin
          $display("%0t: current_length mismatch: expected %0d actual %0d", $time,
                   want.current_length, res_o.current_length);
          error_count++;
        end
      end
    end
  end

  // Requests on an empty list
  task automatic test_empty_list();
    send_item(make_req(plid_pkg::FUNC_READ, 0, 32'h0), 0);
    send_item(make_req(plid_pkg::FUNC_DELETE, 0, 32'h0), 0);
    send_item(make_req(plid_pkg::FUNC_INSERT, 0, 32'h0), 0);  // zero word rejected
    send_item(make_req(plid_pkg::FUNC_CLEAR, 63, 32'hFFFF_FFFF), 0);
  endtask

  // Append past the end, insert at front and middle, reads, deletes
  task automatic test_insert_and_shift();
    send_item(make_req(plid_pkg::FUNC_INSERT, 63, 32'hFFFF_FFFF), 0);
    send_item(make_req(plid_pkg::FUNC_INSERT, 0, 32'h0000_0001), 0);
    send_item(make_req(plid_pkg::FUNC_INSERT, 1, 32'h8000_0000), 0);
    send_item(make_req(plid_pkg::FUNC_READ, 0, 32'h0), 0);
    send_item(make_req(plid_pkg::FUNC_READ, 1, 32'h0), 0);
    send_item(make_req(plid_pkg::FUNC_READ, 2, 32'hFFFF_FFFF), 0);
    send_item(make_req(plid_pkg::FUNC_READ, 3, 32'h0), 0);
    send_item(make_req(plid_pkg::FUNC_DELETE, 1, 32'h0), 0);
    send_item(make_req(plid_pkg::FUNC_DELETE, 1, 32'h0), 0);  // tail entry
    send_item(make_req(plid_pkg::FUNC_READ, 63, 32'h0), 0);
  endtask

  // Full list, position past capacity, capacity lowered below length, extremes
  task automatic test_capacity();
    write_capacity(plid_pkg::LenW'(3));
    send_item(make_req(plid_pkg::FUNC_INSERT, 3, 32'h1234_5678), 0);
    send_item(make_req(plid_pkg::FUNC_INSERT, 2, 32'hA5A5_A5A5), 0);
    send_item(make_req(plid_pkg::FUNC_INSERT, 0, 32'h5A5A_5A5A), 0);
    send_item(make_req(plid_pkg::FUNC_INSERT, 1, 32'hDEAD_BEEF), 0);  // list full
    write_capacity(plid_pkg::LenW'(1));
    send_item(make_req(plid_pkg::FUNC_READ, 2, 32'h0), 0);
    send_item(make_req(plid_pkg::FUNC_DELETE, 0, 32'h0), 0);
    send_item(make_req(plid_pkg::FUNC_INSERT, 0, 32'h0000_0042), 0);
    write_capacity(plid_pkg::LenW'(0));
    send_item(make_req(plid_pkg::FUNC_INSERT, 0, 32'h0000_0007), 0);
    send_item(make_req(plid_pkg::FUNC_CLEAR, 0, 32'h0), 0);
    write_capacity(plid_pkg::LenW'(127));
    send_item(make_req(plid_pkg::FUNC_INSERT, 63, 32'hCAFE_F00D), 0);
  endtask

  // Random traffic over several capacities, idle rates and insert biases
  task automatic test_random_traffic();
    int                         caps     [8] = '{64, 16, 3, 127, 1, 40, 0, 64};
    int                         counts   [8] = '{110, 90, 60, 110, 40, 100, 25, 190};
    int                         idle_pct [4] = '{0, 74, 0, 37};
    int                         ph;
    int                         n;
    int                         ins_w;
    int                         r;
    int                         pos;
    plid_pkg::func_e            f;
    logic [plid_pkg::WordW-1:0] v;
    for (ph = 0; ph < 8; ph++) begin
      write_capacity(plid_pkg::LenW'(caps[ph]));
      for (n = 0; n < counts[ph]; n++) begin
        // alternate between growing and shrinking the list in long stretches
        ins_w = ((n / 40) % 2 == 0) ? 58 : 32;
        r = $urandom_range(99);
        if (r < ins_w) f = plid_pkg::FUNC_INSERT;
        else if (r < ins_w + 22) f = plid_pkg::FUNC_READ;
        else if (r < 98) f = plid_pkg::FUNC_DELETE;
        else f = plid_pkg::FUNC_CLEAR;
        if ($urandom_range(99) < 80) begin
          pos = $urandom_range(list_len);
          if (pos > 63) pos = 63;
        end else begin
          pos = $urandom_range(63);
        end
        r = $urandom_range(99);
        if (r < 5) v = '0;
        else if (r < 10) v = '1;
        else v = $urandom;
        send_item(make_req(f, pos, v), idle_pct[ph % 4]);
      end
    end
  endtask

  // Main sequence
  initial begin
    error_count = 0;
    list_len    = 0;
    cap_limit   = 64;
    foreach (list_words[i]) list_words[i] = '0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_list();
    test_insert_and_shift();
    test_capacity();
    test_random_traffic();

    wait_results_drained();
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
